[src/chbd_pkg.sv]
// Shared types, constants and a helper function for the chunked body decoder.
package chbd_pkg;

    localparam int SizeBits = 32;
    localparam int ByteBits = 8;
    localparam int KindBits = 2;
    localparam int SkipBits = 2;

    localparam logic [ByteBits-1:0] ChCr    = 8'h0D;
    localparam logic [ByteBits-1:0] ChLf    = 8'h0A;
    localparam logic [ByteBits-1:0] ChSpace = 8'h20;
    localparam logic [ByteBits-1:0] ChTab   = 8'h09;

    localparam logic [SkipBits-1:0] TrailerLen = 2'd2;

    typedef enum logic [2:0] {
        PH_LINE = 3'd0,
        PH_DATA = 3'd1,
        PH_SKIP = 3'd2,
        PH_DONE = 3'd3,
        PH_ERR  = 3'd4
    } phase_t;

    typedef enum logic [KindBits-1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_DONE    = 2'd1,
        KIND_BADLINE = 2'd2,
        KIND_TRUNC   = 2'd3
    } kind_t;

    typedef struct packed {
        logic [ByteBits-1:0] body_byte;
        logic                body_end;
    } item_t;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] value;
    } hex_t;

    function automatic hex_t hex_decode(input logic [ByteBits-1:0] c);
        hex_t h;
        h.is_hex = 1'b0;
        h.value  = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.is_hex = 1'b1;
            h.value  = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.is_hex = 1'b1;
            h.value  = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.is_hex = 1'b1;
            h.value  = 4'(c - 8'h37);
        end
        return h;
    endfunction

endpackage

[src/chbd_in_reg.sv]
// Input register that holds one body word until the decoder engine takes it.
module chbd_in_reg (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  chbd_pkg::item_t s_item,
    input  logic           take,
    output logic           item_valid,
    output chbd_pkg::item_t item
);
    import chbd_pkg::*;

    logic  in_valid_reg, in_valid_next;
    item_t in_item_reg, in_item_next;

    assign s_tready   = !in_valid_reg || take;
    assign item_valid = in_valid_reg;
    assign item       = in_item_reg;

    always_comb begin
        in_valid_next = in_valid_reg;
        in_item_next  = in_item_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
            in_item_next  = s_item;
        end else if (take) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
        in_item_reg <= in_item_next;
    end

endmodule

[src/chbd_engine.sv]
// Decoder state, per-byte update logic and the result register.
module chbd_engine (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          item_valid,
    input  chbd_pkg::item_t               item,
    output logic                          take,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [chbd_pkg::ByteBits-1:0] m_byte,
    output logic [chbd_pkg::KindBits-1:0] m_kind
);
    import chbd_pkg::*;

    phase_t              phase_reg, phase_next;
    logic [SizeBits-1:0] chunk_reg, chunk_next;
    logic [SizeBits-1:0] acc_reg, acc_next;
    logic                digit_reg, digit_next;
    logic                ended_reg, ended_next;
    logic                cr_reg, cr_next;
    logic [SkipBits-1:0] skip_reg, skip_next;

    logic                out_valid_reg, out_valid_next;
    logic [ByteBits-1:0] out_byte_reg, out_byte_next;
    kind_t               out_kind_reg, out_kind_next;

    logic                have;
    kind_t               kind;
    logic [ByteBits-1:0] data;
    logic                was_open;
    logic                ended_cr;
    logic                line_err;
    logic [SkipBits-1:0] skip_dec;
    hex_t                hex;

    assign take     = item_valid && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_byte   = out_byte_reg;
    assign m_kind   = out_kind_reg;
    assign hex      = hex_decode(item.body_byte);
    assign was_open = (phase_reg != PH_DONE) && (phase_reg != PH_ERR);
    assign skip_dec = skip_reg - 1'b1;

    always_comb begin
        phase_next = phase_reg;
        chunk_next = chunk_reg;
        acc_next   = acc_reg;
        digit_next = digit_reg;
        ended_next = ended_reg;
        cr_next    = cr_reg;
        skip_next  = skip_reg;
        have       = 1'b0;
        kind       = KIND_PAYLOAD;
        data       = '0;
        ended_cr   = ended_reg || cr_reg;
        line_err   = 1'b0;

        unique case (phase_reg)
            PH_LINE: begin
                if (item.body_byte == ChLf && cr_reg) begin
                    if (!digit_reg) begin
                        phase_next = PH_ERR;
                        have       = 1'b1;
                        kind       = KIND_BADLINE;
                    end else if (acc_reg == '0) begin
                        phase_next = PH_DONE;
                        have       = 1'b1;
                        kind       = KIND_DONE;
                    end else begin
                        chunk_next = acc_reg;
                        phase_next = PH_DATA;
                    end
                    acc_next   = '0;
                    digit_next = 1'b0;
                    ended_next = 1'b0;
                    cr_next    = 1'b0;
                end else begin
                    ended_next = ended_cr;
                    cr_next    = 1'b0;
                    if (item.body_byte == ChCr) begin
                        cr_next = 1'b1;
                    end else if (!ended_cr) begin
                        if (hex.is_hex) begin
                            if (acc_reg[SizeBits-1 -: 4] != 4'd0) begin
                                line_err = 1'b1;
                            end else begin
                                acc_next   = {acc_reg[SizeBits-5:0], hex.value};
                                digit_next = 1'b1;
                            end
                        end else if ((item.body_byte == ChSpace || item.body_byte == ChTab)
                                     && !digit_reg) begin
                            ended_next = 1'b0;
                        end else begin
                            ended_next = 1'b1;
                        end
                    end
                    if (line_err) begin
                        phase_next = PH_ERR;
                        have       = 1'b1;
                        kind       = KIND_BADLINE;
                        acc_next   = '0;
                        digit_next = 1'b0;
                        ended_next = 1'b0;
                        cr_next    = 1'b0;
                    end
                end
            end
            PH_DATA: begin
                have       = 1'b1;
                kind       = KIND_PAYLOAD;
                data       = item.body_byte;
                chunk_next = chunk_reg - 1'b1;
                if (chunk_reg == SizeBits'(1)) begin
                    phase_next = PH_SKIP;
                    skip_next  = TrailerLen;
                end
            end
            PH_SKIP: begin
                skip_next = skip_dec;
                if (skip_dec == '0) begin
                    phase_next = PH_LINE;
                    acc_next   = '0;
                    digit_next = 1'b0;
                    ended_next = 1'b0;
                    cr_next    = 1'b0;
                end
            end
            PH_DONE, PH_ERR: begin
                phase_next = phase_reg;
            end
            default: begin
                phase_next = PH_ERR;
            end
        endcase

        if (item.body_end) begin
            if (was_open && !(have && (kind == KIND_DONE || kind == KIND_BADLINE))) begin
                have = 1'b1;
                kind = KIND_TRUNC;
                data = '0;
            end
            phase_next = PH_LINE;
            chunk_next = '0;
            skip_next  = '0;
            acc_next   = '0;
            digit_next = 1'b0;
            ended_next = 1'b0;
            cr_next    = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_kind_next  = out_kind_reg;
        if (take) begin
            out_valid_next = have;
            out_byte_next  = data;
            out_kind_next  = kind;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_LINE;
            chunk_reg     <= '0;
            acc_reg       <= '0;
            digit_reg     <= 1'b0;
            ended_reg     <= 1'b0;
            cr_reg        <= 1'b0;
            skip_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (take) begin
                phase_reg <= phase_next;
                chunk_reg <= chunk_next;
                acc_reg   <= acc_next;
                digit_reg <= digit_next;
                ended_reg <= ended_next;
                cr_reg    <= cr_next;
                skip_reg  <= skip_next;
            end
            out_valid_reg <= out_valid_next;
        end
        out_byte_reg <= out_byte_next;
        out_kind_reg <= out_kind_next;
    end

endmodule

[src/http_chunked_body_decoder_core.sv]
// Top level of the HTTP/1.1 chunked transfer body decoder.
//
//   Channel  Direction  Word contents
//   s_       in         tdata[7:0] body_byte, tlast body_end
//   m_       out        tdata[7:0] payload_byte, tuser[1:0] result_kind
//
// One body word is taken per clock cycle unless m_ stalls; the decoder update is a single
// pass through the engine, so the sustained rate is one word per cycle.
// A result reaches m_ from its accepted word through the input register, then the result
// register. Words that produce no result leave no output word.
// aresetn is synchronous and returns the decoder to the start of a size line.
// A stall on m_ holds the result register and backs up into the input register.
module http_chunked_body_decoder_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] body_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] payload_byte
    output logic [1:0] m_tuser    // [1:0] result_kind
);
    import chbd_pkg::*;

    item_t s_item;
    item_t item;
    logic  item_valid;
    logic  take;

    assign s_item.body_byte = s_tdata;
    assign s_item.body_end  = s_tlast;

    chbd_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    chbd_engine u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_byte     (m_tdata),
        .m_kind     (m_tuser)
    );

endmodule

[bench/chunked_decode_checker.sv]
`timescale 1ns / 100ps
// Checker that predicts the chunked body decoder's result words and compares them on m_.
module chunked_decode_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tlast,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,
    input  logic [1:0] m_tuser,
    output int         errors,
    output int         pending,
    output int         checked
);
    import chbd_pkg::*;

    typedef struct {
        logic [ByteBits-1:0] payload;
        kind_t               kind;
    } decoded_t;

    decoded_t expected_results[$];
    decoded_t want;

    phase_t              ph;
    logic [SizeBits-1:0] remaining;
    logic [SizeBits-1:0] acc;
    logic                digit_seen;
    logic                number_ended;
    logic                cr_seen;
    logic [SkipBits-1:0] skip_left;

    initial begin
        errors  = 0;
        pending = 0;
        checked = 0;
    end

    task clear_line();
        acc          = '0;
        digit_seen   = 1'b0;
        number_ended = 1'b0;
        cr_seen      = 1'b0;
    endtask

    task reset_decoder();
        ph        = PH_LINE;
        remaining = '0;
        skip_left = '0;
        clear_line();
    endtask

    // One ordinary character of a size line; ok drops on size overflow.
    task line_char(input logic [ByteBits-1:0] c, output logic ok);
        logic       is_digit;
        logic [3:0] nibble;
        ok       = 1'b1;
        is_digit = 1'b1;
        nibble   = 4'd0;
        if (!number_ended) begin
            if (c >= "0" && c <= "9") begin
                nibble = c[3:0];
            end else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
                nibble = c[3:0] + 4'd9;
            end else begin
                is_digit = 1'b0;
            end
            if (is_digit) begin
                if (acc[SizeBits-1 -: 4] != 4'd0) begin
                    ok = 1'b0;
                end else begin
                    acc        = {acc[SizeBits-5:0], nibble};
                    digit_seen = 1'b1;
                end
            end else if ((c == ChSpace || c == ChTab) && !digit_seen) begin
                // Leading blanks are skipped.
            end else begin
                number_ended = 1'b1;
            end
        end
    endtask

    task decode_byte(input logic [ByteBits-1:0] c, input logic last);
        logic     have;
        decoded_t res;
        logic     was_open;
        logic     ok;
        have        = 1'b0;
        res.payload = '0;
        res.kind    = KIND_PAYLOAD;
        was_open    = (ph != PH_DONE && ph != PH_ERR);
        case (ph)
            PH_LINE: begin
                if (c == ChLf && cr_seen) begin
                    if (!digit_seen) begin
                        ph       = PH_ERR;
                        have     = 1'b1;
                        res.kind = KIND_BADLINE;
                    end else if (acc == '0) begin
                        ph       = PH_DONE;
                        have     = 1'b1;
                        res.kind = KIND_DONE;
                    end else begin
                        remaining = acc;
                        ph        = PH_DATA;
                    end
                    clear_line();
                end else begin
                    ok = 1'b1;
                    if (cr_seen) line_char(ChCr, ok);
                    cr_seen = 1'b0;
                    if (ok) begin
                        if (c == ChCr) cr_seen = 1'b1;
                        else line_char(c, ok);
                    end
                    if (!ok) begin
                        ph       = PH_ERR;
                        have     = 1'b1;
                        res.kind = KIND_BADLINE;
                        clear_line();
                    end
                end
            end
            PH_DATA: begin
                have        = 1'b1;
                res.payload = c;
                remaining   = remaining - 1'b1;
                if (remaining == '0) begin
                    ph        = PH_SKIP;
                    skip_left = TrailerLen;
                end
            end
            PH_SKIP: begin
                skip_left = skip_left - 1'b1;
                if (skip_left == '0) begin
                    ph = PH_LINE;
                    clear_line();
                end
            end
            default: begin
            end
        endcase
        if (last) begin
            if (was_open && !(have && (res.kind == KIND_DONE || res.kind == KIND_BADLINE)))
            begin
                have        = 1'b1;
                res.kind    = KIND_TRUNC;
                res.payload = '0;
            end
            reset_decoder();
        end
        if (have) expected_results.insert(expected_results.size(), res);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            reset_decoder();
            expected_results.delete();
        end else begin
            if (s_tvalid && s_tready) decode_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    if (errors < 10)
                        $display("%0t: unexpected result word, kind %0d payload %02h",
                                 $realtime, m_tuser, m_tdata);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    checked++;
                    if (m_tdata !== want.payload || m_tuser !== want.kind) begin
                        if (errors < 10)
                            $display("%0t: expected kind %0d payload %02h, got kind %0d payload %02h",
                                     $realtime, want.kind, want.payload, m_tuser, m_tdata);
                        errors++;
                    end
                end
            end
        end
        pending = expected_results.size();
    end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps
// Top of the chunked body decoder bench: clock, reset, body stimulus and verdict.
module tb_top;
    import chbd_pkg::*;

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;

    int errors;
    int pending;
    int checked;

    int idle_pct;
    int stall_pct;
    int words_sent;
    int bodies_sent;
    int quiet_cycles;

    logic [7:0] body[$];

    http_chunked_body_decoder_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    chunked_decode_checker checker_i (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .errors   (errors),
        .pending  (pending),
        .checked  (checked)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        m_tready = 1'b1;
        forever begin
            @(negedge aclk);
            m_tready = ($urandom_range(99) >= stall_pct);
        end
    end

    // Ends the run when neither channel has moved a word for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= 2000) begin
            $display("Watchdog expired with %0d results outstanding.", pending);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task add_byte(input logic [7:0] b);
        body.insert(body.size(), b);
    endtask

    task push_str(input string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endtask

    task push_crlf();
        add_byte(ChCr);
        add_byte(ChLf);
    endtask

    task push_size_line(input logic [31:0] size);
        string      digits;
        logic [7:0] ch;
        digits = $sformatf("%0h", size);
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 2)) add_byte($urandom_range(1) ? ChSpace : ChTab);
        repeat ($urandom_range(0, 1)) add_byte("0");
        for (int i = 0; i < digits.len(); i++) begin
            ch = digits[i];
            if (ch >= "a" && $urandom_range(1)) ch = ch - 8'h20;
            add_byte(ch);
        end
        if ($urandom_range(3) == 0) begin
            add_byte(";");
            repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range(32, 126)));
        end
        if ($urandom_range(15) == 0) begin
            add_byte(ChCr);
            add_byte("e");
        end
        push_crlf();
    endtask

    task send_body();
        for (int i = 0; i < body.size(); i++) begin
            while ($urandom_range(99) < idle_pct) begin
                s_tvalid = 1'b0;
                @(negedge aclk);
            end
            s_tvalid = 1'b1;
            s_tdata  = body[i];
            s_tlast  = (i == body.size() - 1);
            do @(posedge aclk); while (!s_tready);
            @(negedge aclk);
            words_sent++;
        end
        s_tvalid = 1'b0;
        bodies_sent++;
        body.delete();
    endtask

    task build_random_body();
        int sel;
        int sz;
        int cut;
        sel = $urandom_range(99);
        repeat ($urandom_range(0, 3)) begin
            sz = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            push_size_line(sz);
            repeat (sz) add_byte(8'($urandom_range(255)));
            if ($urandom_range(9) == 0) begin
                add_byte(8'($urandom_range(255)));
                add_byte(8'($urandom_range(255)));
            end else begin
                push_crlf();
            end
        end
        if (sel < 70 || (sel >= 88 && sel < 95)) begin
            push_size_line(0);
            repeat ($urandom_range(0, 2)) add_byte(8'($urandom_range(255)));
            if (sel >= 88) begin
                cut = $urandom_range(0, body.size() - 1);
                while (body.size() > cut + 1) void'(body.pop_back());
            end
        end else if (sel < 80) begin
            case ($urandom_range(5))
                0: push_crlf();
                1: begin push_str("0x1f"); push_crlf(); end
                2: begin push_str("-4"); push_crlf(); end
                3: begin add_byte(ChSpace); add_byte(ChTab); push_str(";a");
                         push_crlf(); end
                4: begin push_str($sformatf("1%08h", $urandom)); push_crlf(); end
                default: begin add_byte(ChLf); add_byte(ChCr);
                               push_crlf(); end
            endcase
            repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range(255)));
        end else if (sel < 88) begin
            push_size_line(32'hFFFF_FFFF);
            repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(255)));
        end else begin
            repeat ($urandom_range(1, 12)) add_byte(8'($urandom_range(255)));
        end
    endtask

    initial begin
        int target;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        idle_pct     = 0;
        stall_pct    = 0;
        words_sent   = 0;
        bodies_sent  = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Blank skipping, extension, payload extremes, then done with swallowed bytes.
        add_byte(ChTab);
        push_str(" 3;e");
        push_crlf();
        add_byte(8'h00);
        add_byte(8'hFF);
        add_byte(8'h80);
        push_crlf();
        push_str("0");
        push_crlf();
        push_crlf();
        send_body();
        push_crlf();
        send_body();
        push_str("1");
        push_crlf();
        push_str("Z");
        send_body();
        push_str("x");
        send_body();
        push_str("aBc123456");
        send_body();
        push_str("0");
        push_crlf();
        send_body();

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 53; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 53; end
                default: begin idle_pct = 20; stall_pct = 20; end
            endcase
            target = words_sent + 490;
            while (words_sent < target) begin
                build_random_body();
                send_body();
            end
        end

        idle_pct  = 0;
        stall_pct = 0;
        while (pending != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);

        $display("Drove %0d body words in %0d bodies under four idling mixes.",
                 words_sent, bodies_sent);
        $display("Compared %0d result words; %0d failures.", checked, errors);
        if (errors == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
